// ===== design/dflc_pkg.sv =====
// shared constants, character codes and code types of the delimited frame length checker
// no dependencies; compiled before every other file of the block
`default_nettype none

package dflc_pkg;

    localparam int DFLC_PREFIX_WINDOW = 29;
    localparam int DFLC_LENGTH_BITS   = 16;
    localparam int STATUS_BITS        = 2;

    // characters the parser reacts to
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // length of the key text "msg_len"
    localparam logic [2:0] KEY_LEN = 3'd7;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 2'd0,
        ST_NO_LEN   = 2'd1,
        ST_MISMATCH = 2'd2
    } t_frame_status;

    // delimiter bytes matched and held back
    typedef enum logic [1:0] {
        DP_NONE    = 2'd0,
        DP_CR      = 2'd1,
        DP_CRLF    = 2'd2,
        DP_CRLFCR  = 2'd3
    } t_delim;

    typedef enum logic [1:0] {
        NP_SKIP   = 2'd0,
        NP_DIGITS = 2'd1,
        NP_ENDED  = 2'd2
    } t_num_phase;

    // characters of the key text by position
    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h6D; // m
            3'd1:    c = 8'h73; // s
            3'd2:    c = 8'h67; // g
            3'd3:    c = 8'h5F; // _
            3'd4:    c = 8'h6C; // l
            3'd5:    c = 8'h65; // e
            3'd6:    c = 8'h6E; // n
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/dflc_rx_if.sv =====
// byte stream channel of the frame length checker: valid, ready and one received byte
// depends on nothing
`default_nettype none

interface dflc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== design/dflc_res_if.sv =====
// result channel of the frame length checker: valid, ready and one frame verdict
// depends on dflc_pkg for the default length width and status width
`default_nettype none

interface dflc_res_if
    import dflc_pkg::*;
#(
    parameter int LENGTH_BITS = DFLC_LENGTH_BITS
);
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] frame_status;
    logic [LENGTH_BITS-1:0] declared_length;
    logic [LENGTH_BITS-1:0] frame_length;

    modport source (output valid, output frame_status, output declared_length,
                    output frame_length, input ready);
    modport sink   (input valid, input frame_status, input declared_length,
                    input frame_length, output ready);
endinterface

`default_nettype wire

// ===== design/delimited_frame_length_checker.sv =====
// timing: a byte is registered, then judged in the next cycle; a verdict appears on
// o_res once the final LF of the delimiter has passed the input and then the output register
// throughput: one byte per clock, set by the single pass through the parser step;
// stalls only while a verdict waits in the output register and another frame ends
// reset: synchronous active-low i_rst_n clears all frame state and the valid bits of both registers
`default_nettype none

module delimited_frame_length_checker
    import dflc_pkg::*;
#(
    parameter int PREFIX_WINDOW = DFLC_PREFIX_WINDOW,
    parameter int LENGTH_BITS   = DFLC_LENGTH_BITS
)(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dflc_rx_if.sink     i_rx,
    dflc_res_if.source  o_res
);

    // input register: one byte transaction held for the parser
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // output register: one verdict waiting for the sink
    logic                   r_out_valid;
    t_frame_status          r_out_status;
    logic [LENGTH_BITS-1:0] r_out_decl;
    logic [LENGTH_BITS-1:0] r_out_flen;

    // parser outputs for the held byte
    logic                   eof;
    t_frame_status          status;
    logic [LENGTH_BITS-1:0] declared;
    logic [LENGTH_BITS-1:0] flen;
    logic                   adv;

    dflc_parser #(
        .PREFIX_WINDOW (PREFIX_WINDOW),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (adv),
        .i_byte     (r_in_byte),
        .o_eof      (eof),
        .o_status   (status),
        .o_declared (declared),
        .o_flen     (flen)
    );

    // the held byte moves on unless it closes a frame while the verdict slot is full and not being taken
    assign adv = r_in_valid && (!eof || !r_out_valid || o_res.ready);

    // a new byte can enter whenever no byte is held or the held one leaves in the same cycle
    assign i_rx.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && eof) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && eof) begin
            r_out_status <= status;
            r_out_decl   <= declared;
            r_out_flen   <= flen;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.frame_status    = r_out_status;
    assign o_res.declared_length = r_out_decl;
    assign o_res.frame_length    = r_out_flen;

    // a matching frame reports equal lengths
    a_ok_lengths: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_status == ST_OK)
            |-> (o_res.declared_length == o_res.frame_length))
        else $error("ok verdict with unequal lengths");

    // missing length field reports zero declared length
    a_nolen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_status == ST_NO_LEN) |-> (o_res.declared_length == '0))
        else $error("missing length with nonzero declared length");

    // a frame end stalled behind a waiting verdict blocks the input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && eof && r_out_valid && !o_res.ready) |-> !i_rx.ready)
        else $error("input taken while frame end is stalled");

    // a verdict appears only after a frame end was processed
    a_verdict_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(adv && eof))
        else $error("verdict without a frame end");

endmodule

`default_nettype wire

// ===== design/dflc_parser.sv =====
// frame state, delimiter tracking and header token parsing for one byte per step
// depends on dflc_pkg
`default_nettype none

module dflc_parser
    import dflc_pkg::*;
#(
    parameter int PREFIX_WINDOW = DFLC_PREFIX_WINDOW,
    parameter int LENGTH_BITS   = DFLC_LENGTH_BITS
)(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic [7:0]             i_byte,
    output logic                        o_eof,
    output t_frame_status               o_status,
    output logic [LENGTH_BITS-1:0]      o_declared,
    output logic [LENGTH_BITS-1:0]      o_flen
);

    localparam int LB = LENGTH_BITS;
    localparam logic [LB:0]   WINDOW  = (LB+1)'(PREFIX_WINDOW);
    localparam logic [LB:0]   LEN_CAP = {1'b1, {LB{1'b0}}};
    localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

    typedef struct packed {
        logic          in_token;
        logic [2:0]    key_prog;
        logic          has_key;
        logic          key_seen;
        logic          value_done;
        t_num_phase    phase;
        logic          neg;
        logic [LB:0]   accum;
        logic [LB:0]   parsed;
        logic [LB:0]   count;
    } t_fstate;

    localparam t_fstate FS_CLEAR = '{
        in_token: 1'b0, key_prog: 3'd0, has_key: 1'b0, key_seen: 1'b0,
        value_done: 1'b0, phase: NP_SKIP, neg: 1'b0,
        accum: '0, parsed: '0, count: '0
    };

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b inside {[CH_TAB:CH_CR]});
    endfunction

    function automatic t_fstate end_token(input t_fstate s);
        t_fstate r;
        r = s;
        if (s.in_token) begin
            r.in_token = 1'b0;
            if (s.has_key) begin
                r.key_seen = 1'b1;
            end else if (s.key_seen) begin
                r.parsed     = s.accum;
                r.value_done = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_fstate token_byte(input t_fstate s, input logic [7:0] b);
        t_fstate     r;
        logic [LB+4:0] prod;
        r = s;
        prod = '0;
        if (b == CH_NUL) begin
            r = end_token(r);
            r.value_done = 1'b1;
        end else if (b == CH_COMMA || b == CH_COLON) begin
            r = end_token(r);
        end else begin
            if (!r.in_token) begin
                r.in_token = 1'b1;
                r.key_prog = 3'd0;
                r.has_key  = 1'b0;
                r.phase    = NP_SKIP;
                r.neg      = 1'b0;
                r.accum    = '0;
            end
            if (!r.has_key) begin
                if (b == key_char(r.key_prog)) begin
                    r.key_prog = r.key_prog + 3'd1;
                end else begin
                    r.key_prog = (b == key_char(3'd0)) ? 3'd1 : 3'd0;
                end
                if (r.key_prog == KEY_LEN) begin
                    r.has_key = 1'b1;
                end
            end
            // atoi style: whitespace, optional sign, then digits
            if (r.phase == NP_SKIP && is_space(b)) begin
                r.phase = NP_SKIP;
            end else if (r.phase == NP_SKIP && (b == CH_PLUS || b == CH_MINUS)) begin
                r.neg   = (b == CH_MINUS);
                r.phase = NP_DIGITS;
            end else if (r.phase != NP_ENDED && b >= CH_ZERO && b <= CH_NINE) begin
                prod = ({4'b0, r.accum} << 3) + ({4'b0, r.accum} << 1)
                     + (LB+5)'(b[3:0]);
                r.accum = (prod > {4'b0, LEN_CAP}) ? LEN_CAP : prod[LB:0];
                r.phase = NP_DIGITS;
            end else begin
                r.phase = NP_ENDED;
            end
        end
        return r;
    endfunction

    function automatic t_fstate frame_byte(input t_fstate s, input logic [7:0] b);
        t_fstate r;
        r = s;
        if (s.count < WINDOW && !s.value_done) begin
            r = token_byte(r, b);
            // token still open as the window fills ends there
            if (s.count == WINDOW - (LB+1)'(1) && !r.value_done) begin
                r = end_token(r);
            end
        end
        if (s.count < LEN_CAP) begin
            r.count = s.count + (LB+1)'(1);
        end
        return r;
    endfunction

    t_delim  r_dp, n_dp;
    t_fstate r_fs, n_fs;
    t_fstate s1, s2, s3, s4, s_end;
    logic    is_cr, is_lf, plain;
    logic    rel1, rel2, rel3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp <= DP_NONE;
            r_fs <= FS_CLEAR;
        end else if (i_step) begin
            r_dp <= n_dp;
            r_fs <= n_fs;
        end
    end

    always_comb begin
        is_cr = (i_byte == CH_CR);
        is_lf = (i_byte == CH_LF);
        o_eof = is_lf && (r_dp == DP_CRLFCR);
        plain = !is_cr && !(is_lf && r_dp == DP_CR) && !o_eof;

        // held bytes released ahead of the new one: CR, LF, CR in order
        rel1 = (is_cr && (r_dp == DP_CR || r_dp == DP_CRLFCR)) || (plain && r_dp != DP_NONE);
        rel2 = (is_cr && r_dp == DP_CRLFCR) || (plain && (r_dp == DP_CRLF || r_dp == DP_CRLFCR));
        rel3 = (is_cr && r_dp == DP_CRLFCR) || (plain && r_dp == DP_CRLFCR);

        s1 = rel1  ? frame_byte(r_fs, CH_CR) : r_fs;
        s2 = rel2  ? frame_byte(s1, CH_LF)   : s1;
        s3 = rel3  ? frame_byte(s2, CH_CR)   : s2;
        s4 = plain ? frame_byte(s3, i_byte)  : s3;

        // delimiter next state
        n_dp = DP_NONE;
        case (r_dp)
            DP_NONE:   n_dp = is_cr ? DP_CR : DP_NONE;
            DP_CR:     n_dp = is_cr ? DP_CR : (is_lf ? DP_CRLF : DP_NONE);
            DP_CRLF:   n_dp = is_cr ? DP_CRLFCR : DP_NONE;
            DP_CRLFCR: n_dp = is_cr ? DP_CR : DP_NONE;
            default:   n_dp = DP_NONE;
        endcase

        // verdict of the frame closed by this byte
        s_end = r_fs;
        if (r_fs.count < WINDOW && !r_fs.value_done) begin
            s_end = end_token(r_fs);
        end
        o_flen = s_end.count[LB] ? LEN_MAX : s_end.count[LB-1:0];
        if (s_end.parsed == '0) begin
            o_status   = ST_NO_LEN;
            o_declared = '0;
        end else if (s_end.neg) begin
            o_status   = ST_MISMATCH;
            o_declared = '0;
        end else begin
            o_declared = s_end.parsed[LB] ? LEN_MAX : s_end.parsed[LB-1:0];
            o_status   = (s_end.parsed == s_end.count) ? ST_OK : ST_MISMATCH;
        end

        n_fs = o_eof ? FS_CLEAR : s4;
    end

endmodule

`default_nettype wire

// ===== dv/tb_delimited_frame_length_checker.sv =====
`timescale 1ns / 100ps
// self-checking testbench of delimited_frame_length_checker: byte driver, verdict monitor
// depends on dflc_pkg, dflc_rx_if, dflc_res_if and the checker itself

module tb_delimited_frame_length_checker;
    import dflc_pkg::*;

    localparam int LEN_W = DFLC_LENGTH_BITS;
    localparam int PW    = DFLC_PREFIX_WINDOW;
    // saturation point of the frame counters and the largest reported length
    localparam logic [LEN_W:0]   LEN_CAP = {1'b1, {LEN_W{1'b0}}};
    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [55:0]      KEY_STR = "msg_len";

    localparam int RANDOM_BYTES   = 1150;
    localparam int PRESSURE_AFTER = 10;     // verdicts seen before the long hold-off
    localparam int PRESSURE_HOLD  = 400;
    localparam int IDLE_LIMIT     = 2000;   // cycles with no transaction on either side
    localparam int DRAIN_CYCLES   = 12;

    typedef struct packed {
        t_frame_status    status;
        logic [LEN_W-1:0] declared;
        logic [LEN_W-1:0] length;
    } t_frame_verdict;

    logic i_clk;
    logic i_rst_n;

    dflc_rx_if  rx_ch ();
    dflc_res_if res_ch ();

    delimited_frame_length_checker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    // bytes waiting for the driver, and the frame being assembled
    logic [7:0]     pending_bytes[$];
    logic [7:0]     frame_buf[$];
    t_frame_verdict expected_verdicts[$];

    int mismatch_count = 0;
    int verdicts_seen  = 0;
    int regular_bytes  = 0;

    // driver and sink pacing
    int   rx_gap        = 0;
    int   rx_quiet      = 0;
    int   res_stall     = 0;
    int   res_quiet     = 0;
    int   hold_left     = 0;
    bit   pressure_done = 1'b0;
    logic long_hold     = 1'b0;
    int   idle_cycles   = 0;

    // ------------------------------------------------------------------
    // frame length predictor state
    // ------------------------------------------------------------------
    t_delim     dlm_state;
    logic [16:0] frm_count;
    logic       tok_open;
    logic [2:0] key_match;
    logic       tok_keyed;
    logic       key_armed;
    logic       parse_stop;
    t_num_phase num_phase;
    logic       num_neg;
    logic [16:0] num_acc;
    logic [16:0] len_value;

    function automatic logic [7:0] key_at(input logic [2:0] idx);
        return KEY_STR[8*(6-idx) +: 8];
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    task automatic clear_frame_state();
        frm_count  = '0;
        tok_open   = 1'b0;
        key_match  = '0;
        tok_keyed  = 1'b0;
        key_armed  = 1'b0;
        parse_stop = 1'b0;
        num_phase  = NP_SKIP;
        num_neg    = 1'b0;
        num_acc    = '0;
        len_value  = '0;
    endtask

    // a token ends: either it armed the reader or it carried the value
    task automatic close_token();
        if (tok_open) begin
            tok_open = 1'b0;
            if (tok_keyed) begin
                key_armed = 1'b1;
            end else if (key_armed) begin
                len_value  = num_acc;
                parse_stop = 1'b1;
            end
        end
    endtask

    task automatic scan_token_byte(input logic [7:0] b);
        logic [31:0] acc;
        if (b == CH_NUL) begin
            // nul ends the token and parsing for the rest of the frame
            close_token();
            parse_stop = 1'b1;
        end else if (b == CH_COMMA || b == CH_COLON) begin
            close_token();
        end else begin
            if (!tok_open) begin
                tok_open  = 1'b1;
                key_match = '0;
                tok_keyed = 1'b0;
                num_phase = NP_SKIP;
                num_neg   = 1'b0;
                num_acc   = '0;
            end
            if (!tok_keyed) begin
                if (b == key_at(key_match))
                    key_match = key_match + 3'd1;
                else
                    key_match = (b == key_at(3'd0)) ? 3'd1 : 3'd0;
                if (key_match >= KEY_LEN) begin
                    tok_keyed = 1'b1;
                    key_match = KEY_LEN;
                end
            end
            // atoi-like read: blanks, sign, digits, anything else ends it
            if (num_phase == NP_SKIP && is_blank(b)) begin
                // leading blank skipped
            end else if (num_phase == NP_SKIP && (b == CH_PLUS || b == CH_MINUS)) begin
                num_neg   = (b == CH_MINUS);
                num_phase = NP_DIGITS;
            end else if (num_phase != NP_ENDED && b >= CH_ZERO && b <= CH_NINE) begin
                acc = num_acc * 10 + (b - CH_ZERO);
                if (acc > LEN_CAP)
                    acc = LEN_CAP;
                num_acc   = acc[16:0];
                num_phase = NP_DIGITS;
            end else begin
                num_phase = NP_ENDED;
            end
        end
    endtask

    task automatic feed_frame_byte(input logic [7:0] b);
        if (frm_count < PW && !parse_stop) begin
            scan_token_byte(b);
            // the token open when the window fills ends there
            if (frm_count + 1 == PW && !parse_stop)
                close_token();
        end
        if (frm_count < LEN_CAP)
            frm_count = frm_count + 17'd1;
    endtask

    // held delimiter bytes become frame bytes in their order
    task automatic release_held(input int n);
        for (int i = 0; i < n; i++)
            feed_frame_byte((i == 1) ? CH_LF : CH_CR);
    endtask

    task automatic predict_rx_byte(input logic [7:0] b);
        t_frame_verdict v;
        if (b == CH_CR) begin
            case (dlm_state)
                DP_CR: begin
                    release_held(1);
                    dlm_state = DP_CR;
                end
                DP_CRLF: begin
                    dlm_state = DP_CRLFCR;
                end
                DP_CRLFCR: begin
                    release_held(3);
                    dlm_state = DP_CR;
                end
                default: begin
                    dlm_state = DP_CR;
                end
            endcase
        end else if (b == CH_LF && dlm_state == DP_CR) begin
            dlm_state = DP_CRLF;
        end else if (!(b == CH_LF && dlm_state == DP_CRLFCR)) begin
            release_held(int'(dlm_state));
            feed_frame_byte(b);
            dlm_state = DP_NONE;
        end else begin
            // delimiter complete: one verdict per frame
            if (frm_count < PW && !parse_stop)
                close_token();
            v.length = (frm_count > LEN_MAX) ? LEN_MAX : frm_count[LEN_W-1:0];
            if (len_value == '0) begin
                v.status   = ST_NO_LEN;
                v.declared = '0;
            end else if (num_neg) begin
                v.status   = ST_MISMATCH;
                v.declared = '0;
            end else begin
                v.declared = (len_value > LEN_MAX) ? LEN_MAX : len_value[LEN_W-1:0];
                v.status   = (len_value == frm_count) ? ST_OK : ST_MISMATCH;
            end
            expected_verdicts.push_back(v);
            dlm_state = DP_NONE;
            clear_frame_state();
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_sep();
        return ($urandom_range(0, 1) == 1) ? CH_COLON : CH_COMMA;
    endfunction

    // mostly printable, with some CR, LF, nul and high bytes
    function automatic logic [7:0] filler_byte();
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 70)      c = 8'($urandom_range(32, 126));
        else if (r < 78) c = CH_CR;
        else if (r < 84) c = CH_LF;
        else if (r < 87) c = CH_NUL;
        else             c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            frame_buf.push_back(s[i]);
    endtask

    task automatic add_word(input int n);
        logic [7:0] c;
        repeat (n) begin
            c = 8'($urandom_range(8'h61, 8'h7A));
            frame_buf.push_back(c);
        end
    endtask

    task automatic add_filler(input int n);
        repeat (n) frame_buf.push_back(filler_byte());
    endtask

    // optional leading token, key token, optional second key, then the value token
    task automatic add_header(input bit twice, input int nsp, input logic [7:0] sign,
                              input string digits);
        int n;
        n = $urandom_range(0, 4);
        if (n > 0) begin
            add_word(n);
            frame_buf.push_back(pick_sep());
        end
        add_word($urandom_range(0, 2));
        add_text("msg_len");
        add_word($urandom_range(0, 2));
        frame_buf.push_back(pick_sep());
        if (twice) begin
            add_text("msg_len");
            frame_buf.push_back(pick_sep());
        end
        repeat (nsp) frame_buf.push_back(($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE);
        if (sign != CH_NUL)
            frame_buf.push_back(sign);
        add_text(digits);
        frame_buf.push_back(CH_COMMA);
    endtask

    task automatic commit_frame();
        regular_bytes += frame_buf.size() + 4;
        foreach (frame_buf[i])
            pending_bytes.push_back(frame_buf[i]);
        pending_bytes.push_back(CH_CR);
        pending_bytes.push_back(CH_LF);
        pending_bytes.push_back(CH_CR);
        pending_bytes.push_back(CH_LF);
        frame_buf.delete();
    endtask

    task automatic add_random_frame();
        int         kind;
        int         flen;
        int         rem;
        int         fl;
        int         a;
        logic [7:0] sign;
        kind = $urandom_range(0, 99);
        sign = ($urandom_range(0, 3) == 0) ? CH_PLUS : CH_NUL;
        flen = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(26, 80);
        if (kind < 40) begin
            // declared length matches the frame
            add_header(1'b0, $urandom_range(0, 2), sign, $sformatf("%0d", flen));
            add_filler(flen - frame_buf.size());
        end else if (kind < 52) begin
            add_header(1'b0, $urandom_range(0, 1), sign,
                       $sformatf("%0d", $urandom_range(1, 120)));
            add_filler($urandom_range(0, 40));
        end else if (kind < 58) begin
            // no key at all
            add_filler($urandom_range(0, 40));
        end else if (kind < 63) begin
            add_header(1'b0, $urandom_range(0, 1), CH_MINUS,
                       $sformatf("%0d", $urandom_range(1, 500)));
            add_filler($urandom_range(0, 30));
        end else if (kind < 67) begin
            // zero in its spellings, minus zero among them
            case ($urandom_range(0, 3))
                0:       add_header(1'b0, 0, CH_MINUS, "0");
                1:       add_header(1'b0, 1, CH_PLUS, "0");
                2:       add_header(1'b0, 0, CH_NUL, "0");
                default: add_header(1'b0, 0, CH_NUL, "00");
            endcase
            add_filler($urandom_range(0, 20));
        end else if (kind < 72) begin
            // repeated key keeps the reader armed
            flen = $urandom_range(35, 80);
            add_header(1'b1, 0, CH_NUL, $sformatf("%0d", flen));
            add_filler(flen - frame_buf.size());
        end else if (kind < 77) begin
            // nul somewhere in the header stops parsing
            add_header(1'b0, 0, CH_NUL, $sformatf("%0d", flen));
            frame_buf.insert($urandom_range(0, frame_buf.size()), CH_NUL);
            add_filler(flen - frame_buf.size());
        end else if (kind < 82) begin
            // key near the end of the window, value cut off there
            add_word($urandom_range(8, 26));
            frame_buf.push_back(pick_sep());
            add_text("msg_len:");
            add_text($sformatf("%0d", $urandom_range(1, 99999)));
            add_filler($urandom_range(0, 20));
        end else if (kind < 87) begin
            // value beyond the length range
            add_header(1'b0, 0, CH_NUL, $sformatf("%0d", $urandom_range(65536, 999999999)));
            add_filler($urandom_range(0, 30));
        end else if (kind < 94) begin
            // partial delimiter inside the body, released as frame bytes
            flen = $urandom_range(30, 80);
            add_header(1'b0, 0, CH_NUL, $sformatf("%0d", flen));
            rem = flen - frame_buf.size();
            fl  = $urandom_range(1, 3);
            a   = $urandom_range(0, rem - fl - 1);
            add_word(a);
            frame_buf.push_back(CH_CR);
            if (fl > 1) frame_buf.push_back(CH_LF);
            if (fl > 2) frame_buf.push_back(CH_CR);
            add_word(rem - fl - a);
        end else begin
            // raw noise, any byte value
            repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom_range(0, 255)));
        end
        commit_frame();
    endtask

    task automatic build_stimulus();
        // directed: exact match with no trailing comma, empty frame,
        // held CR before the delimiter, held CR LF CR before the delimiter
        add_text("msg_len:9");
        commit_frame();
        commit_frame();
        frame_buf.push_back(CH_CR);
        commit_frame();
        frame_buf.push_back(CH_CR);
        frame_buf.push_back(CH_LF);
        frame_buf.push_back(CH_CR);
        commit_frame();
        while (regular_bytes < RANDOM_BYTES)
            add_random_frame();
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // clock, reset and run control
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n        = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        res_ch.ready   = 1'b0;
        dlm_state      = DP_NONE;
        clear_frame_state();
        build_stimulus();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // every byte offered and taken
        while (pending_bytes.size() != 0 || rx_ch.valid)
            @(posedge i_clk);
        // every verdict back, then a drain wait for anything stray
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // byte driver: one transaction at a time, random gaps between them
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : rx_driver
        if (!i_rst_n) begin
            rx_ch.valid <= 1'b0;
        end else if (rx_ch.valid && !rx_ch.ready) begin
            // transaction still offered, hold byte and valid
        end else if (rx_gap > 0 && !long_hold) begin
            rx_gap--;
            rx_ch.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
            rx_ch.valid   <= 1'b1;
            rx_ch.rx_byte <= pending_bytes.pop_front();
            // keep offering while the sink holds off, so the block backs up
            if (long_hold) begin
                rx_gap = 0;
            end else if (rx_quiet > 0) begin
                rx_quiet--;
                rx_gap = 0;
            end else begin
                rx_gap = pick_gap();
                if ($urandom_range(0, 199) == 0)
                    rx_quiet = $urandom_range(50, 200);
            end
        end else begin
            rx_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // verdict sink: random stalls, one long hold-off early in the run
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : res_sink
        if (!pressure_done && verdicts_seen >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            hold_left     = PRESSURE_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
            long_hold    <= 1'b1;
        end else if (res_stall > 0) begin
            res_stall--;
            res_ch.ready <= 1'b0;
            long_hold    <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
            long_hold    <= 1'b0;
            if (res_quiet > 0) begin
                res_quiet--;
            end else begin
                if ($urandom_range(0, 2) == 0)
                    res_stall = pick_gap();
                if ($urandom_range(0, 299) == 0)
                    res_quiet = $urandom_range(50, 200);
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on every byte transaction, check every verdict
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : stream_monitor
        t_frame_verdict want;
        if (i_rst_n) begin
            if (rx_ch.valid && rx_ch.ready)
                predict_rx_byte(rx_ch.rx_byte);
            if (res_ch.valid && res_ch.ready) begin
                verdicts_seen++;
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("verdict %0d/%0d/%0d with no frame ended",
                                              res_ch.frame_status, res_ch.declared_length,
                                              res_ch.frame_length));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (res_ch.frame_status !== want.status)
                        report_mismatch($sformatf("frame_status %0d, expected %0d",
                                                  res_ch.frame_status, want.status));
                    if (res_ch.declared_length !== want.declared)
                        report_mismatch($sformatf("declared_length %0d, expected %0d",
                                                  res_ch.declared_length, want.declared));
                    if (res_ch.frame_length !== want.length)
                        report_mismatch($sformatf("frame_length %0d, expected %0d",
                                                  res_ch.frame_length, want.length));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction means the block hung
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : idle_watchdog
        if (i_rst_n) begin
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
